/* rtl/rhc_pkg.sv */
package rhc_pkg;

  // Field widths of the pixel words
  localparam int COMP_W  = 16;
  localparam int HUE_W   = 15;
  localparam int LIGHT_W = 16;
  localparam int SAT_W   = 16;

  // Parameter defaults
  localparam int COMPONENT_BITS_DEF    = 16;
  localparam int HUE_FRACTION_BITS_DEF = 6;

  // Whole degrees below 360 fit in 9 bits
  localparam int DEG_FULL = 360;
  localparam int DEG_BITS = 9;

  localparam logic [HUE_W-1:0] HUE_FIELD_MAX = 15'h7FFF;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

endpackage

/* rtl/rhc_rgb_if.sv */
interface rhc_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [rhc_pkg::COMP_W-1:0] red_in;
  logic [rhc_pkg::COMP_W-1:0] green_in;
  logic [rhc_pkg::COMP_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

/* rtl/rhc_hsl_if.sv */
interface rhc_hsl_if;
  logic                        valid;
  logic                        ready;
  logic [rhc_pkg::HUE_W-1:0]   hue_out;
  logic [rhc_pkg::LIGHT_W-1:0] lightness_out;
  logic [rhc_pkg::SAT_W-1:0]   saturation_out;

  modport source (output valid, output hue_out, output lightness_out,
                  output saturation_out, input ready);
  modport sink   (input valid, input hue_out, input lightness_out,
                  input saturation_out, output ready);
endinterface

/* rtl/rhc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// num must satisfy num < div * 2**QW. Stages past QW only hold the word.
module rhc_div #(
  parameter int DW     = 16,
  parameter int QW     = 16,
  parameter int STAGES = 16
) (
  input  logic              clk,
  input  logic [STAGES-1:0] en,
  input  logic [DW+QW-1:0]  num,
  input  logic [DW-1:0]     div,
  output logic [QW-1:0]     quo
);

  localparam int AW = DW + QW;

  // acc holds {partial remainder, numerator bits left, quotient bits so far}
  logic [AW-1:0] acc [STAGES];
  logic [DW-1:0] dvr [STAGES];

  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] a,
                                             input logic [DW-1:0] d);
    logic [DW:0]   trial;
    logic [DW-1:0] rem;
    logic          qbit;
    trial = a[AW-1:QW-1];
    qbit  = (trial >= {1'b0, d});
    if (qbit) begin
      rem = DW'(trial - {1'b0, d});
    end else begin
      rem = trial[DW-1:0];
    end
    return {rem, a[QW-2:0], qbit};
  endfunction

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [AW-1:0] acc_prev;
    logic [DW-1:0] dvr_prev;

    if (i == 0) begin : g_first
      assign acc_prev = num;
      assign dvr_prev = div;
    end else begin : g_next
      assign acc_prev = acc[i-1];
      assign dvr_prev = dvr[i-1];
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        dvr[i] <= dvr_prev;
        if (i < QW) begin
          acc[i] <= div_step(acc_prev, dvr_prev);
        end else begin
          acc[i] <= acc_prev;
        end
      end
    end
  end

  assign quo = acc[STAGES-1][QW-1:0];

endmodule

/* rtl/rgb_to_hsl_converter.sv */
// Channel  Dir  Word                                    Accepted when
// rgb      in   red_in, green_in, blue_in               rgb.valid && rgb.ready
// hsl      out  hue_out, lightness_out, saturation_out  hsl.valid && hsl.ready
//
// Throughput one word per clock while hsl is ready; stages are s1..s4, the
// two bit-per-stage dividers, and the output register.
// rst (synchronous) clears only the stage valid bits; no other state.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and a stall at hsl holds every word in place.
module rgb_to_hsl_converter #(
  parameter int COMPONENT_BITS    = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  rhc_rgb_if.sink  rgb,
  rhc_hsl_if.source hsl
);

  localparam int CB  = COMPONENT_BITS;
  localparam int HFB = HUE_FRACTION_BITS;
  // hue quotient bits: degrees below 360 plus fraction
  localparam int HQW = rhc_pkg::DEG_BITS + HFB;
  localparam int HNW = CB + HQW;        // hue numerator
  localparam int MW  = CB + rhc_pkg::DEG_BITS;  // 60 * f
  localparam int FW  = CB + 3;          // f < 6 * spread
  localparam int L   = (HQW > CB) ? HQW : CB;   // divider depth
  localparam int NS  = L + 5;           // s1..s4, divider, output
  localparam int DS  = 4;               // first divider stage index
  localparam int HXW = (HQW > rhc_pkg::HUE_W) ? HQW : rhc_pkg::HUE_W;
  localparam int HueLimitRaw = (rhc_pkg::DEG_FULL << HFB) - 1;
  localparam int HueLimit = (HueLimitRaw > int'(rhc_pkg::HUE_FIELD_MAX)) ?
                            int'(rhc_pkg::HUE_FIELD_MAX) : HueLimitRaw;
  localparam logic [CB-1:0] FS = {CB{1'b1}};

  // ---------------------------------------------------------------------
  // Stage control: v = occupied, en = stage loads this cycle
  // ---------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  assign en[NS-1] = !v[NS-1] || hsl.ready;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign rgb.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= rgb.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // s1: max / min; ties go red, then green
  // ---------------------------------------------------------------------
  logic [CB-1:0] r_in, g_in, b_in;
  logic [CB-1:0] r1, g1, b1, hi1, lo1;
  logic          gbge1;
  rhc_pkg::max_sel_t sel1;
  rhc_pkg::max_sel_t sel_next;
  logic [CB-1:0] hi_next, lo_next;

  assign r_in = rgb.red_in[CB-1:0];
  assign g_in = rgb.green_in[CB-1:0];
  assign b_in = rgb.blue_in[CB-1:0];

  always_comb begin
    if (r_in >= g_in && r_in >= b_in) begin
      sel_next = rhc_pkg::MAX_RED;
      hi_next  = r_in;
    end else if (g_in >= b_in) begin
      sel_next = rhc_pkg::MAX_GREEN;
      hi_next  = g_in;
    end else begin
      sel_next = rhc_pkg::MAX_BLUE;
      hi_next  = b_in;
    end
    lo_next = r_in;
    if (g_in < lo_next) lo_next = g_in;
    if (b_in < lo_next) lo_next = b_in;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r1    <= r_in;
      g1    <= g_in;
      b1    <= b_in;
      hi1   <= hi_next;
      lo1   <= lo_next;
      sel1  <= sel_next;
      gbge1 <= (g_in >= b_in);
    end
  end

  // ---------------------------------------------------------------------
  // s2: sum, spread, lightness, component difference for the sextant
  // ---------------------------------------------------------------------
  logic [CB:0]        sum2;
  logic [CB-1:0]      spread2;
  logic signed [CB:0] diff2;
  logic signed [CB:0] diff_next;
  logic               gbge2;
  rhc_pkg::max_sel_t  sel2;

  always_comb begin
    unique case (sel1)
      rhc_pkg::MAX_RED:   diff_next = $signed({1'b0, g1}) - $signed({1'b0, b1});
      rhc_pkg::MAX_GREEN: diff_next = $signed({1'b0, b1}) - $signed({1'b0, r1});
      rhc_pkg::MAX_BLUE:  diff_next = $signed({1'b0, r1}) - $signed({1'b0, g1});
      default:            diff_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum2    <= {1'b0, hi1} + {1'b0, lo1};
      spread2 <= hi1 - lo1;
      diff2   <= diff_next;
      gbge2   <= gbge1;
      sel2    <= sel1;
    end
  end

  // ---------------------------------------------------------------------
  // s3: saturation divisor, hue numerator in sixtieths (f)
  //   red max:  f = g - b, or 6*spread + (g - b) when negative
  //   green:    f = 2*spread + b - r
  //   blue:     f = 4*spread + r - g
  // ---------------------------------------------------------------------
  logic [CB-1:0] den3, spread3, light3;
  logic [FW-1:0] f3;
  logic          grey3;
  logic [FW-1:0] sp_x, base_next;
  logic [CB:0]   den_hi;

  assign sp_x   = FW'(spread2);
  assign den_hi = {FS, 1'b0} - sum2;

  always_comb begin
    unique case (sel2)
      rhc_pkg::MAX_RED:   base_next = gbge2 ? '0 : (sp_x << 2) + (sp_x << 1);
      rhc_pkg::MAX_GREEN: base_next = sp_x << 1;
      rhc_pkg::MAX_BLUE:  base_next = sp_x << 2;
      default:            base_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      den3    <= (sum2 <= {1'b0, FS}) ? sum2[CB-1:0] : den_hi[CB-1:0];
      f3      <= base_next + {{2{diff2[CB]}}, diff2};
      spread3 <= spread2;
      light3  <= sum2[CB:1];
      grey3   <= (spread2 == '0);
    end
  end

  // ---------------------------------------------------------------------
  // s4: scale numerators: hue * 60 * 2^HFB, saturation spread * FS
  // ---------------------------------------------------------------------
  logic [HNW-1:0]  hnum4;
  logic [2*CB-1:0] snum4;
  logic [CB-1:0]   den4, spread4, light4;
  logic            grey4;
  logic [MW-1:0]   f_x, f60;

  assign f_x = MW'(f3);
  assign f60 = (f_x << 6) - (f_x << 2);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hnum4   <= HNW'(f60) << HFB;
      snum4   <= ({CB'(0), spread3} << CB) - {CB'(0), spread3};
      den4    <= den3;
      spread4 <= spread3;
      light4  <= light3;
      grey4   <= grey3;
    end
  end

  // ---------------------------------------------------------------------
  // Divider pipelines; lightness and grey flag ride alongside
  // ---------------------------------------------------------------------
  logic [HQW-1:0] hue_quo;
  logic [CB-1:0]  sat_quo;
  logic [CB-1:0]  light_d [L];
  logic           grey_d  [L];

  rhc_div #(.DW(CB), .QW(HQW), .STAGES(L)) u_hue_div (
    .clk (clk),
    .en  (en[DS +: L]),
    .num (hnum4),
    .div (spread4),
    .quo (hue_quo)
  );

  rhc_div #(.DW(CB), .QW(CB), .STAGES(L)) u_sat_div (
    .clk (clk),
    .en  (en[DS +: L]),
    .num (snum4),
    .div (den4),
    .quo (sat_quo)
  );

  for (genvar i = 0; i < L; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[DS+i]) begin
        light_d[i] <= (i == 0) ? light4 : light_d[(i == 0) ? 0 : i-1];
        grey_d[i]  <= (i == 0) ? grey4  : grey_d[(i == 0) ? 0 : i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: clamp hue to the field, zero hue/sat for grey
  // ---------------------------------------------------------------------
  logic [HXW-1:0]           hue_x;
  logic [rhc_pkg::HUE_W-1:0] hue_c;

  assign hue_x = HXW'(hue_quo);
  assign hue_c = (hue_x > HXW'(rhc_pkg::HUE_FIELD_MAX)) ? rhc_pkg::HUE_FIELD_MAX
                                                        : hue_x[rhc_pkg::HUE_W-1:0];

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      hsl.hue_out        <= grey_d[L-1] ? '0 : hue_c;
      hsl.lightness_out  <= rhc_pkg::LIGHT_W'(light_d[L-1]);
      hsl.saturation_out <= grey_d[L-1] ? '0 : rhc_pkg::SAT_W'(sat_quo);
    end
  end

  assign hsl.valid = v[NS-1];

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    rgb.valid && rgb.ready |=> v[0])
    else $error("accepted word not captured in first stage");

  a_first_holds : assert property (@(posedge clk) disable iff (rst)
    v[0] && !en[0] |=> v[0])
    else $error("stalled first stage dropped its word");

  a_sat_zero_grey : assert property (@(posedge clk) disable iff (rst)
    hsl.valid && hsl.saturation_out == '0 |-> hsl.hue_out == '0)
    else $error("zero saturation with nonzero hue");

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    hsl.valid |-> 32'(hsl.hue_out) <= 32'(HueLimit))
    else $error("hue out of range");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

// RGB to HSL converter testbench.
// Pixels go in through rgb, HSL words come out through hsl. Every accepted
// pixel is run through a local fixed-point model of the conversion, and the
// expected HSL word is queued. Words leave the block in order, so each
// output word is checked against the head of that queue.
module tb;

  localparam int COMP_BITS = rhc_pkg::COMPONENT_BITS_DEF;
  localparam int HUE_FRAC  = rhc_pkg::HUE_FRACTION_BITS_DEF;

  // Fixed-point scale factors. Hue is kept in degrees << HUE_FRAC.
  localparam longint unsigned FULL     = (64'd1 << COMP_BITS) - 1;
  localparam longint unsigned HUE_ONE  = 64'd1 << HUE_FRAC;
  localparam longint unsigned SEXTANT  = (rhc_pkg::DEG_FULL / 6) * HUE_ONE;
  localparam longint unsigned CIRCLE   = rhc_pkg::DEG_FULL * HUE_ONE;
  localparam longint unsigned FIELD_HI = rhc_pkg::HUE_FIELD_MAX;

  localparam int N_RANDOM   = 1630;
  localparam int CALM_LO    = 700;    // no idling on either side in [CALM_LO, CALM_HI)
  localparam int CALM_HI    = 1100;
  localparam int DRAIN_AT_A = 25;     // sender waits for an empty pipe before these
  localparam int DRAIN_AT_B = 1300;
  localparam int STUCK_MAX  = 2000;   // cycles with no handshake before giving up
  localparam int TAIL_WAIT  = 40;     // idle margin after the last checked word

  typedef struct {
    logic [rhc_pkg::COMP_W-1:0] red;
    logic [rhc_pkg::COMP_W-1:0] green;
    logic [rhc_pkg::COMP_W-1:0] blue;
    bit                         drain;  // hold this word until every result is back
  } pixel_t;

  typedef struct {
    logic [rhc_pkg::HUE_W-1:0]   hue;
    logic [rhc_pkg::LIGHT_W-1:0] light;
    logic [rhc_pkg::SAT_W-1:0]   sat;
  } hsl_t;

  logic clk;
  logic rst;

  rhc_rgb_if rgb ();
  rhc_hsl_if hsl ();

  rgb_to_hsl_converter #(
    .COMPONENT_BITS    (COMP_BITS),
    .HUE_FRACTION_BITS (HUE_FRAC)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .rgb (rgb),
    .hsl (hsl)
  );

  pixel_t      pix_q[$];       // stimulus waiting to be driven
  hsl_t        hsl_expect[$];  // predicted words, oldest first
  int unsigned pix_sent;       // pixels accepted by the block
  int unsigned pix_done;       // HSL words accepted from the block
  int unsigned n_errors;
  int unsigned stuck_cycles;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Expected HSL for one pixel. All arithmetic in 64 bits; each quotient is
  // truncated, then hue and saturation are clamped to their ranges.
  function automatic hsl_t rgb_to_hsl(pixel_t p);
    longint unsigned r, g, b, hi, lo, sum, spread, den, num, hue, sat;
    hsl_t w;
    r = p.red & FULL;
    g = p.green & FULL;
    b = p.blue & FULL;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sum    = hi + lo;
    spread = hi - lo;
    hue    = 0;
    sat    = 0;
    if (spread != 0) begin
      // lightness <= 1/2 tested exactly as sum <= full scale
      den = (sum <= FULL) ? sum : (2 * FULL - sum);
      if (den != 0) sat = (spread * FULL) / den;
      if (sat > FULL) sat = FULL;
      // max ties: red beats green, green beats blue
      if (r == hi) begin
        if (g >= b) num = SEXTANT * (g - b);
        else num = CIRCLE * spread - SEXTANT * (b - g);  // wrap negative hue
      end else if (g == hi) begin
        num = 2 * SEXTANT * spread + SEXTANT * b - SEXTANT * r;
      end else begin
        num = 4 * SEXTANT * spread + SEXTANT * r - SEXTANT * g;
      end
      hue = num / spread;
      if (hue > CIRCLE - 1) hue = CIRCLE - 1;
      if (hue > FIELD_HI) hue = FIELD_HI;
    end
    w.hue   = hue[rhc_pkg::HUE_W-1:0];
    w.light = sum[rhc_pkg::LIGHT_W:1];
    w.sat   = sat[rhc_pkg::SAT_W-1:0];
    return w;
  endfunction

  // ~7% idle, except inside the calm window
  function automatic bit take_break(int unsigned n);
    if (n >= CALM_LO && n < CALM_HI) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  function automatic pixel_t mk_pixel(longint unsigned r, longint unsigned g,
                                      longint unsigned b);
    pixel_t p;
    p.red   = r[rhc_pkg::COMP_W-1:0];
    p.green = g[rhc_pkg::COMP_W-1:0];
    p.blue  = b[rhc_pkg::COMP_W-1:0];
    p.drain = 1'b0;
    return p;
  endfunction

  // Random pixel, biased toward the corners of the conversion: greys,
  // equal pairs of components, tiny spreads, sums around full scale, and extreme codes.
  function automatic pixel_t rand_pixel();
    longint unsigned v[3];
    longint unsigned corner[6];
    longint unsigned base;
    int unsigned k;
    corner = '{0, 1, FULL - 1, FULL, FULL / 2, FULL / 2 + 1};
    for (int i = 0; i < 3; i++) v[i] = $urandom_range(FULL);
    case ($urandom_range(9))
      5: begin
        v[1] = v[0];
        v[2] = v[0];
      end
      6: begin
        k = $urandom_range(2);
        v[(k + 1) % 3] = v[k];
      end
      7: begin
        base = $urandom_range(FULL - 8);
        for (int i = 0; i < 3; i++) v[i] = base + $urandom_range(7);
      end
      8: begin
        // hi + lo lands within a few codes of full scale
        base = $urandom_range(FULL);
        v[0] = base;
        v[1] = FULL - base + $urandom_range(2);
        if (v[1] > FULL) v[1] = FULL;
        v[2] = (v[0] + v[1]) / 2;
      end
      9: begin
        for (int i = 0; i < 3; i++) v[i] = corner[$urandom_range(5)];
      end
      default: ;
    endcase
    return mk_pixel(v[0], v[1], v[2]);
  endfunction

  // Driver: presents the next pixel whenever the bus is free, or drops valid
  // on an idle cycle or while a drain point waits for the pipe to empty.
  always @(posedge clk) begin : drv
    int unsigned sent_now;
    pixel_t p;
    sent_now = pix_sent;
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (!rgb.valid || rgb.ready) begin
      if (rgb.valid) begin
        p = mk_pixel(rgb.red_in, rgb.green_in, rgb.blue_in);
        hsl_expect.push_back(rgb_to_hsl(p));
        sent_now++;
        pix_sent <= sent_now;
      end
      if (pix_q.size() != 0 && !take_break(sent_now) &&
          !(pix_q[0].drain && sent_now != pix_done)) begin
        p = pix_q.pop_front();
        rgb.valid    <= 1'b1;
        rgb.red_in   <= p.red;
        rgb.green_in <= p.green;
        rgb.blue_in  <= p.blue;
      end else begin
        rgb.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted HSL word against the oldest prediction
  // and stalls hsl.ready at random.
  always @(posedge clk) begin : mon
    hsl_t want;
    int unsigned done_now;
    int unsigned err_now;
    done_now = pix_done;
    err_now  = n_errors;
    if (rst) begin
      hsl.ready <= 1'b0;
    end else begin
      if (hsl.valid && hsl.ready) begin
        done_now++;
        pix_done <= done_now;
        if (hsl_expect.size() == 0) begin
          $error("unexpected word: hue=%0d lightness=%0d saturation=%0d",
                 hsl.hue_out, hsl.lightness_out, hsl.saturation_out);
          err_now++;
        end else begin
          want = hsl_expect.pop_front();
          if (hsl.hue_out !== want.hue) begin
            $error("hue_out: expected %0d, got %0d", want.hue, hsl.hue_out);
            err_now++;
          end
          if (hsl.lightness_out !== want.light) begin
            $error("lightness_out: expected %0d, got %0d", want.light, hsl.lightness_out);
            err_now++;
          end
          if (hsl.saturation_out !== want.sat) begin
            $error("saturation_out: expected %0d, got %0d", want.sat, hsl.saturation_out);
            err_now++;
          end
        end
        n_errors <= err_now;
      end
      hsl.ready <= !take_break(done_now);
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (rgb.valid && rgb.ready) || (hsl.valid && hsl.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    pixel_t p;
    rst            = 1'b1;
    rgb.valid      = 1'b0;
    rgb.red_in     = '0;
    rgb.green_in   = '0;
    rgb.blue_in    = '0;
    hsl.ready      = 1'b0;
    pix_sent       = 0;
    pix_done       = 0;
    n_errors       = 0;
    stuck_cycles   = 0;

    // Directed words
    pix_q.push_back(mk_pixel(0, 0, 0));                  // black
    pix_q.push_back(mk_pixel(FULL, FULL, FULL));         // white
    pix_q.push_back(mk_pixel(FULL / 2, FULL / 2, FULL / 2)); // mid grey
    pix_q.push_back(mk_pixel(FULL, 0, 0));               // primaries
    pix_q.push_back(mk_pixel(0, FULL, 0));
    pix_q.push_back(mk_pixel(0, 0, FULL));
    pix_q.push_back(mk_pixel(FULL, FULL, 0));            // red/green tie for max
    pix_q.push_back(mk_pixel(0, FULL, FULL));            // green/blue tie for max
    pix_q.push_back(mk_pixel(FULL, 0, FULL));            // red/blue tie for max
    pix_q.push_back(mk_pixel(FULL, 0, 100));             // red max, green < blue
    pix_q.push_back(mk_pixel(FULL, 1, 2));               // hue just under 360
    pix_q.push_back(mk_pixel(FULL / 2 + 1, FULL / 2, FULL / 2));     // sum == full scale
    pix_q.push_back(mk_pixel(FULL / 2 + 2, FULL / 2, FULL / 2));     // sum just above
    pix_q.push_back(mk_pixel(1, 0, 0));                  // smallest spread, dark
    pix_q.push_back(mk_pixel(FULL, FULL - 1, FULL - 1)); // smallest spread, bright
    pix_q.push_back(mk_pixel(0, 1, 2));
    pix_q.push_back(mk_pixel(16'h1234, 16'hABCD, 16'hFEDC));
    pix_q.push_back(mk_pixel(16'hFFFF, 16'hAAAA, 16'h5555));
    pix_q.push_back(mk_pixel(16'h5555, 16'hAAAA, 16'hFFFF));
    pix_q.push_back(mk_pixel(16'hAAAA, 16'h5555, 16'hFFFF));

    for (int i = 0; i < N_RANDOM; i++) begin
      p = rand_pixel();
      p.drain = (i == DRAIN_AT_A) || (i == DRAIN_AT_B);
      pix_q.push_back(p);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pix_q.size() != 0 || rgb.valid) @(posedge clk);
    while (hsl_expect.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* rgb_to_hsl_converter.f */
rtl/rhc_pkg.sv
rtl/rhc_rgb_if.sv
rtl/rhc_hsl_if.sv
rtl/rhc_div.sv
rtl/rgb_to_hsl_converter.sv
test/tb.sv
